// File: design/dqvm_pkg.sv
// ----------------------------------------------------------------------------
// dqvm_pkg
// Shared types, constants and the 4x quadrature transition table for the
// dual quadrature velocity meter.
// ----------------------------------------------------------------------------
package dqvm_pkg;

    // Position counter width (legal range 8 to 32).
    localparam int COUNT_WIDTH = 16;

    // Fixed field widths of the result beat.
    localparam int VEL_W = 24;
    localparam int POS_W = 16;
    localparam int CFG_W = 8;

    // Signed product of a count difference and the 8-bit unsigned scale.
    localparam int PROD_W    = COUNT_WIDTH + CFG_W + 1;
    localparam int MUL_W     = (PROD_W > VEL_W) ? PROD_W : VEL_W;
    localparam int POS_EXT_W = (COUNT_WIDTH > POS_W) ? COUNT_WIDTH : POS_W;

    localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    // Register map.
    localparam int ADDR_W = 3;
    localparam logic REG_TICKS = 1'b0;
    localparam logic REG_SCALE = 1'b1;

    localparam logic [CFG_W-1:0] TICKS_RESET = 8'd20;
    localparam logic [CFG_W-1:0] SCALE_RESET = 8'd30;

    // Input beat kinds.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_UP,
        STEP_DOWN
    } step_t;

    // Indexed by {previous A/B, current A/B}.
    localparam step_t STEP_TABLE [16] = '{
        STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE,
        STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
        STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
        STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE
    };

    function automatic logic [COUNT_WIDTH-1:0] advance(
        input logic [COUNT_WIDTH-1:0] count,
        input logic [1:0]             prev_ab,
        input logic [1:0]             cur_ab
    );
        logic [COUNT_WIDTH-1:0] result;
        result = count;
        case (STEP_TABLE[{prev_ab, cur_ab}])
            STEP_UP:   result = count + COUNT_WIDTH'(1);
            STEP_DOWN: result = count - COUNT_WIDTH'(1);
            default:   result = count;
        endcase
        return result;
    endfunction

endpackage

// File: design/dual_quadrature_velocity_meter.sv
// ----------------------------------------------------------------------------
// dual_quadrature_velocity_meter
// Two 4x quadrature decoders with a shared tick-based velocity window.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while s_ready is high. A pin-sample beat
// steps both position counters through the 4x transition table and gives no
// result; a tick beat advances the window counter, and the tick that completes
// a window of ticks_per_window ticks (0 behaves as 1) yields one result beat
// carrying both velocities (scale times the count change since the previous
// window close, saturated to 24 bits) and both positions. A result passes
// from its closing tick through the first stage and then the second: the first
// registers the count differences and positions, the second applies the scale
// multiply and the saturation. s_ready drops only while both stages hold results
// and the downstream side is stalling. Configuration is to be written over the
// APB port while no beat is in flight; the block itself does not enforce this.
module dual_quadrature_velocity_meter
    import dqvm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_req_type,
    input  logic [1:0]              s_enc1_ab,
    input  logic [1:0]              s_enc2_ab,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VEL_W-1:0] m_velocity_one,
    output logic signed [VEL_W-1:0] m_velocity_two,
    output logic signed [POS_W-1:0] m_position_one,
    output logic signed [POS_W-1:0] m_position_two
);

    // Configuration registers.
    logic [CFG_W-1:0] ticks_reg;
    logic [CFG_W-1:0] scale_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= TICKS_RESET;
            scale_reg <= SCALE_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_TICKS: ticks_reg <= pwdata[CFG_W-1:0];
                REG_SCALE: scale_reg <= pwdata[CFG_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TICKS: prdata = 32'(ticks_reg);
            REG_SCALE: prdata = 32'(scale_reg);
            default:   prdata = '0;
        endcase
    end

    // Decoder and window state.
    logic [COUNT_WIDTH-1:0] count_one_reg, count_one_next;
    logic [COUNT_WIDTH-1:0] count_two_reg, count_two_next;
    logic [1:0]             prev_ab_one_reg, prev_ab_two_reg;
    logic [COUNT_WIDTH-1:0] start_one_reg, start_two_reg;
    logic [CFG_W-1:0]       tick_count_reg, tick_count_next;
    logic [CFG_W:0]         tick_inc;
    logic                   in_beat;
    logic                   is_tick;
    logic                   window_close;

    // Stage 1: differences and positions of a closed window.
    logic                          s1_valid_reg;
    logic signed [COUNT_WIDTH-1:0] s1_diff_one_reg, s1_diff_two_reg;
    logic signed [POS_W-1:0]       s1_pos_one_reg, s1_pos_two_reg;
    logic                          s1_advance;
    logic                          m_free;

    logic signed [POS_EXT_W-1:0]   pos_one_ext, pos_two_ext;

    assign m_free     = !m_valid || m_ready;
    assign s1_advance = s1_valid_reg && m_free;
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign in_beat    = s_valid && s_ready;
    assign is_tick    = (s_req_type == REQ_TICK);

    assign tick_inc     = {1'b0, tick_count_reg} + (CFG_W+1)'(1);
    // A zero window length compares as always reached.
    assign window_close = (tick_inc >= {1'b0, ticks_reg});

    always_comb begin
        count_one_next  = advance(count_one_reg, prev_ab_one_reg, s_enc1_ab);
        count_two_next  = advance(count_two_reg, prev_ab_two_reg, s_enc2_ab);
        tick_count_next = window_close ? '0 : tick_inc[CFG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_one_reg   <= '0;
            count_two_reg   <= '0;
            prev_ab_one_reg <= '0;
            prev_ab_two_reg <= '0;
            start_one_reg   <= '0;
            start_two_reg   <= '0;
            tick_count_reg  <= '0;
        end else if (in_beat) begin
            if (!is_tick) begin
                count_one_reg   <= count_one_next;
                count_two_reg   <= count_two_next;
                prev_ab_one_reg <= s_enc1_ab;
                prev_ab_two_reg <= s_enc2_ab;
            end else begin
                tick_count_reg <= tick_count_next;
                if (window_close) begin
                    start_one_reg <= count_one_reg;
                    start_two_reg <= count_two_reg;
                end
            end
        end
    end

    assign pos_one_ext = POS_EXT_W'($signed(count_one_reg));
    assign pos_two_ext = POS_EXT_W'($signed(count_two_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_beat && is_tick && window_close) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat && is_tick && window_close) begin
            s1_diff_one_reg <= $signed(count_one_reg - start_one_reg);
            s1_diff_two_reg <= $signed(count_two_reg - start_two_reg);
            s1_pos_one_reg  <= pos_one_ext[POS_W-1:0];
            s1_pos_two_reg  <= pos_two_ext[POS_W-1:0];
        end
    end

    // Stage 2: scale and saturate into the output register.
    logic signed [CFG_W:0]       scale_s;
    logic signed [PROD_W-1:0]    prod_one, prod_two;
    logic signed [MUL_W-1:0]     prod_one_ext, prod_two_ext;
    logic signed [VEL_W-1:0]     vel_one_next, vel_two_next;
    logic                        m_valid_reg;
    logic signed [VEL_W-1:0]     vel_one_reg, vel_two_reg;
    logic signed [POS_W-1:0]     pos_one_reg, pos_two_reg;

    assign scale_s      = $signed({1'b0, scale_reg});
    assign prod_one     = PROD_W'(s1_diff_one_reg) * PROD_W'(scale_s);
    assign prod_two     = PROD_W'(s1_diff_two_reg) * PROD_W'(scale_s);
    assign prod_one_ext = MUL_W'(prod_one);
    assign prod_two_ext = MUL_W'(prod_two);

    always_comb begin
        if (prod_one_ext > MUL_W'(VEL_MAX)) begin
            vel_one_next = VEL_MAX;
        end else if (prod_one_ext < MUL_W'(VEL_MIN)) begin
            vel_one_next = VEL_MIN;
        end else begin
            vel_one_next = prod_one_ext[VEL_W-1:0];
        end
        if (prod_two_ext > MUL_W'(VEL_MAX)) begin
            vel_two_next = VEL_MAX;
        end else if (prod_two_ext < MUL_W'(VEL_MIN)) begin
            vel_two_next = VEL_MIN;
        end else begin
            vel_two_next = prod_two_ext[VEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            vel_one_reg <= vel_one_next;
            vel_two_reg <= vel_two_next;
            pos_one_reg <= s1_pos_one_reg;
            pos_two_reg <= s1_pos_two_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_velocity_one = vel_one_reg;
    assign m_velocity_two = vel_two_reg;
    assign m_position_one = pos_one_reg;
    assign m_position_two = pos_two_reg;

`ifndef SYNTH
    // A window-closing tick always lands in the first stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat && is_tick && window_close |=> s1_valid_reg)
        else $error("closing tick did not load the first stage");

    // Pin samples never move the window counter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat && !is_tick |=> $stable(tick_count_reg))
        else $error("pin sample changed the tick count");

    // Ticks never move the position counters.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat && is_tick |=> $stable(count_one_reg) && $stable(count_two_reg))
        else $error("tick changed a position counter");

    // A held first stage keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_advance |=>
            s1_valid_reg && $stable(s1_diff_one_reg) && $stable(s1_diff_two_reg))
        else $error("stalled first stage lost its contents");

    // A new result beat only comes from a filled first stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("result beat without a first-stage entry");
`endif

endmodule
